[rtl/core/wah_pkg.sv]
// Package for the in-place WAH bitmap accumulator.
// Holds sizes, operation and status codes, the sequencer state type, the merge
// result struct and the run word builder. No dependencies.
package wah_pkg;

   localparam int MaxSlots = 4096;
   localparam int SlotW    = $clog2(MaxSlots) + 1;   // holds 0..MaxSlots
   localparam int AddrW    = $clog2(MaxSlots);

   localparam logic [31:0] LIT_ONES  = 32'h7fff_ffff;
   localparam logic [31:0] FILL_FLAG = 32'h8000_0000;

   localparam logic [2:0] OP_CLEAR = 3'd0;
   localparam logic [2:0] OP_SET   = 3'd1;
   localparam logic [2:0] OP_OR    = 3'd2;
   localparam logic [2:0] OP_AND   = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_ZERO_FILL = 2'd1;
   localparam logic [1:0] STAT_OVERRUN   = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_READ,
      S_RWAIT,
      S_MOD,
      S_REM,
      S_RESP
   } state_type;

   typedef struct packed {
      logic             main_we;
      logic [31:0]      main_word;
      logic [SlotW-1:0] num;
      logic             rem_we;
      logic [31:0]      rem_word;
   } merge_type;

   // A run of n slots of value val; a single slot becomes a literal.
   function automatic logic [31:0] run_word(input logic val, input logic [29:0] n);
      logic [31:0] w;
      if (n > 30'd1) begin
         w = {1'b1, val, n};
      end else begin
         w = val ? LIT_ONES : 32'd0;
      end
      return w;
   endfunction

endpackage

[rtl/core/wah_inplace_bitmap_and_or.sv]
// In-place WAH bitmap accumulator with OR/AND of streamed operand words.
// Clear and set write slot 0; rejected, unused and out-of-range requests go straight to the
// response; a read waits on the registered store output; an operand merges each accumulator
// run or literal it covers, writing a split remainder (single-port store, one access a cycle).
// One transaction in the sequencer at a time; a stalled result holds the next one in it.
// Reset clears control, position 0, total_slots 4096; store is undefined until written.
module wah_inplace_bitmap_and_or
   import wah_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [31:0] operand_word, [43:32] slot_index, zero pad
   input  logic [3:0]  req_tuser,   // [2:0] operation, [3] start_of_operand
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [31:0] read_word, [33:32] status, [46:34] position
   input  logic        csr_we,
   input  logic [12:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [SlotW-1:0] total_ff;
   logic [SlotW-1:0] lim;
   logic [SlotW-1:0] cur_ff, cur_in;
   logic [SlotW-1:0] p_ff, p_in;
   logic [SlotW-1:0] left_ff, left_in;
   logic [31:0]      rem_ff, rem_in;
   logic [31:0]      rd_ff, rd_in;
   logic [1:0]       st_ff, st_in;

   logic [2:0]       op_ff;
   logic             start_ff;
   logic [31:0]      word_ff;
   logic [AddrW-1:0] sidx_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      out_rd_ff;
   logic [1:0]       out_st_ff;
   logic [SlotW-1:0] out_pos_ff;
   logic             out_load;

   logic             ram_we;
   logic [AddrW-1:0] ram_addr;
   logic [31:0]      ram_wdata;
   logic [31:0]      ram_rdata;

   merge_type        mrg;

   logic [SlotW-1:0] p_sel;
   logic [29:0]      need;

   always_comb begin
      if (total_ff > SlotW'(MaxSlots)) begin
         lim = SlotW'(MaxSlots);
      end else if (total_ff < SlotW'(2)) begin
         lim = SlotW'(2);
      end else begin
         lim = total_ff;
      end
   end

   wah_ram u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   wah_merge u_merge (
      .acc_word (ram_rdata),
      .opd_word (word_ff),
      .is_and   (op_ff == OP_AND),
      .left     (left_ff),
      .pos      (p_ff),
      .lim      (lim),
      .res      (mrg)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, out_pos_ff, out_st_ff, out_rd_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= SlotW'(MaxSlots);
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            total_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ff    <= p_in;
      left_ff <= left_in;
      rem_ff  <= rem_in;
      rd_ff   <= rd_in;
      st_ff   <= st_in;
      if (req_tvalid && req_tready) begin
         op_ff    <= req_tuser[2:0];
         start_ff <= req_tuser[3];
         word_ff  <= req_tdata[31:0];
         sidx_ff  <= req_tdata[32 +: AddrW];
      end
      if (out_load) begin
         out_rd_ff  <= rd_ff;
         out_st_ff  <= st_ff;
         out_pos_ff <= cur_ff;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      p_in      = p_ff;
      left_in   = left_ff;
      rem_in    = rem_ff;
      rd_in     = rd_ff;
      st_in     = st_ff;
      ram_we    = 1'b0;
      ram_addr  = p_ff[AddrW-1:0];
      ram_wdata = mrg.main_word;
      out_load  = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      p_sel = start_ff ? '0 : cur_ff;
      need  = word_ff[31] ? word_ff[29:0] : 30'd1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            rd_in    = 32'd0;
            st_in    = STAT_OK;
            state_in = S_RESP;
            if (op_ff == OP_CLEAR || op_ff == OP_SET) begin
               ram_we    = 1'b1;
               ram_addr  = '0;
               ram_wdata = FILL_FLAG | {1'b0, op_ff[0], {(30-SlotW){1'b0}}, lim};
               cur_in    = '0;
            end else if (op_ff == OP_READ) begin
               ram_addr = sidx_ff;
               if ({1'b0, sidx_ff} < lim) begin
                  state_in = S_RWAIT;
               end
            end else if (op_ff == OP_OR || op_ff == OP_AND) begin
               cur_in = p_sel;
               if (word_ff[31] && need == 30'd0) begin
                  st_in = STAT_ZERO_FILL;
               end else if (p_sel >= lim
                            || need > {{(30-SlotW){1'b0}}, lim - p_sel}) begin
                  st_in = STAT_OVERRUN;
               end else begin
                  p_in     = p_sel;
                  left_in  = need[SlotW-1:0];
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_MOD;
         end
         S_RWAIT: begin
            rd_in    = ram_rdata;
            state_in = S_RESP;
         end
         S_MOD: begin
            ram_we  = mrg.main_we;
            p_in    = p_ff + mrg.num;
            left_in = left_ff - mrg.num;
            rem_in  = mrg.rem_word;
            if (mrg.rem_we) begin
               state_in = S_REM;
            end else if (left_ff == mrg.num) begin
               cur_in   = p_ff + mrg.num;
               state_in = S_RESP;
            end else begin
               state_in = S_READ;
            end
         end
         S_REM: begin
            // Split remainder goes right behind the merged run
            ram_we    = 1'b1;
            ram_wdata = rem_ff;
            if (left_ff == '0) begin
               cur_in   = p_ff;
               state_in = S_RESP;
            end else begin
               state_in = S_READ;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOD) |-> (p_ff < lim))
      else $error("merge walk left the bitmap range");

   a_walk_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ || state_ff == S_MOD) |-> (left_ff != '0))
      else $error("slot access issued with no run left");

   a_rem_after_mod: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REM) |-> ($past(state_ff) == S_MOD))
      else $error("remainder write without preceding merge");

   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      (cur_ff <= SlotW'(MaxSlots)))
      else $error("position beyond maximum slot count");

endmodule

[rtl/core/wah_ram.sv]
// Single-port accumulator store, one access per cycle, registered read data.
// Depends on wah_pkg for depth and address width.
module wah_ram
   import wah_pkg::*;
(
   input  logic             clock,
   input  logic             we,
   input  logic [AddrW-1:0] addr,
   input  logic [31:0]      wdata,
   output logic [31:0]      rdata
);

   logic [31:0] mem [MaxSlots];
   logic [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/wah_merge.sv]
// Merge unit for OR and AND: combines one accumulator word with the operand word at
// the current slot, splitting fills at the shorter run. Depends on wah_pkg.
module wah_merge
   import wah_pkg::*;
(
   input  logic [31:0]      acc_word,
   input  logic [31:0]      opd_word,
   input  logic             is_and,
   input  logic [SlotW-1:0] left,
   input  logic [SlotW-1:0] pos,
   input  logic [SlotW-1:0] lim,
   output merge_type        res
);

   logic             a_fill;
   logic             av;
   logic             fv;
   logic [29:0]      alen;
   logic [29:0]      rem_n;
   logic [SlotW-1:0] num;
   logic [SlotW:0]   next_pos;
   logic             v;

   always_comb begin
      a_fill = acc_word[31];
      av     = acc_word[30];
      fv     = opd_word[30];
      // A zero-length accumulator fill counts as one slot
      alen   = (acc_word[29:0] == 30'd0) ? 30'd1 : acc_word[29:0];
      v      = is_and ? (av & fv) : (av | fv);

      res.main_we   = 1'b1;
      res.main_word = 32'd0;
      res.rem_we    = 1'b0;
      num           = SlotW'(1);

      if (opd_word[31] && a_fill) begin
         if ({{(30-SlotW){1'b0}}, left} < alen) begin
            num = left;
         end else begin
            num = alen[SlotW-1:0];
         end
         res.main_word = run_word(v, {{(30-SlotW){1'b0}}, num});
      end else if (opd_word[31]) begin
         // Literal under a fill operand: only a dominating fill changes it
         res.main_we   = is_and ? !fv : fv;
         res.main_word = fv ? LIT_ONES : 32'd0;
      end else if (a_fill) begin
         if (is_and) begin
            res.main_word = av ? opd_word : 32'd0;
         end else begin
            res.main_word = av ? LIT_ONES : opd_word;
         end
      end else begin
         res.main_word = is_and ? (acc_word & opd_word) : (acc_word | opd_word);
      end

      rem_n         = alen - {{(30-SlotW){1'b0}}, num};
      next_pos      = {1'b0, pos} + {1'b0, num};
      res.num       = num;
      res.rem_word  = run_word(av, rem_n);
      // Drop a remainder that would land at or past the end
      res.rem_we    = a_fill && (alen > {{(30-SlotW){1'b0}}, num})
                      && (next_pos < {1'b0, lim});
   end

endmodule
